// File: design/a64lsu_pkg.sv
package a64lsu_pkg;

    // item kinds
    localparam logic [1:0] KIND_EXEC      = 2'd0;
    localparam logic [1:0] KIND_SET_REG   = 2'd1;
    localparam logic [1:0] KIND_WRITE_MEM = 2'd2;
    localparam logic [1:0] KIND_SET_PC    = 2'd3;

    localparam int         NUM_REGS  = 31;
    localparam logic [4:0] ZERO_REG  = 5'd31;
    localparam int         NUM_BANKS = 8;
    localparam int         BANK_W    = 3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] instr;
        logic [4:0]  reg_number;
        logic [15:0] mem_address;
        logic [63:0] value;
    } in_item_t;

    typedef struct packed {
        logic [63:0] access_address;
        logic        is_load;
        logic        is_wide;
        logic [63:0] transfer_value;
        logic [4:0]  target_number;
        logic        base_written;
        logic [4:0]  base_number;
        logic [63:0] base_value;
        logic [63:0] pc_after;
    } out_item_t;

    typedef struct packed {
        logic clear;     // zero one memory row
        logic accept;    // latch item, read Rn and Rm
        logic calc;      // address add, base writeback, read Rt
        logic mem;       // bank read or bank write
        logic load_wb;   // assemble load data, write Rt
        logic res_load;  // load the output register
    } lsu_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic setup_only;
        logic needs_load;
    } lsu_status_t;

endpackage

// File: design/a64_load_store_unit.sv
// channel  ports                     transfer when
// input    s_valid s_ready s_data    s_valid && s_ready
// result   m_valid m_ready m_data    m_valid && m_ready
//
// Items pass the calc state (register file read, address add) and then fin; set
// register / set pc go straight there, stores and memory setup writes add mem,
// loads add mem and load for the registered read of the eight byte-lane memory banks.
// After reset the memory is zeroed one row of eight bytes per cycle, with s_ready
// low. MEM_BYTES must be a power of two; the block itself does not enforce it.
// A held result does not block the next item until that item finishes.
module a64_load_store_unit #(
    parameter int MEM_BYTES = 65536
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  a64lsu_pkg::in_item_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output a64lsu_pkg::out_item_t m_data
);
    import a64lsu_pkg::*;

    lsu_cmd_t    cmd;
    lsu_status_t sts;

    a64lsu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    a64lsu_dpath #(
        .MEM_BYTES (MEM_BYTES)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_data  (m_data)
    );

endmodule

// File: design/a64lsu_ctrl.sv
module a64lsu_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    output a64lsu_pkg::lsu_cmd_t   cmd,
    input  a64lsu_pkg::lsu_status_t sts
);
    import a64lsu_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_MEM,
        ST_LOAD,
        ST_FIN
    } state_t;

    state_t state_reg;
    logic   m_valid_reg;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) || ((state_reg == ST_FIN) && out_free);
    assign m_valid  = m_valid_reg;

    always_comb begin
        cmd          = '0;
        cmd.clear    = (state_reg == ST_CLEAR);
        cmd.accept   = s_valid && s_ready;
        cmd.calc     = (state_reg == ST_CALC);
        cmd.mem      = (state_reg == ST_MEM);
        cmd.load_wb  = (state_reg == ST_LOAD);
        cmd.res_load = (state_reg == ST_FIN) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    if (sts.clear_last) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_CALC;
                    end
                end
                ST_CALC: begin
                    state_reg <= sts.setup_only ? ST_FIN : ST_MEM;
                end
                ST_MEM: begin
                    state_reg <= sts.needs_load ? ST_LOAD : ST_FIN;
                end
                ST_LOAD: begin
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    // result goes out while the next item may come in
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= s_valid ? ST_CALC : ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: design/a64lsu_dpath.sv
module a64lsu_dpath #(
    parameter int MEM_BYTES = 65536
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  a64lsu_pkg::in_item_t    s_data,
    input  a64lsu_pkg::lsu_cmd_t    cmd,
    output a64lsu_pkg::lsu_status_t sts,
    output a64lsu_pkg::out_item_t   m_data
);
    import a64lsu_pkg::*;

    localparam int ROWS  = MEM_BYTES / NUM_BANKS;
    localparam int ROW_W = $clog2(ROWS);

    in_item_t  item_reg;
    out_item_t res_reg;

    // register file
    logic [63:0]         rf_mem [NUM_REGS];
    logic [NUM_REGS-1:0] rf_valid_reg;
    logic [63:0]         rda_reg, rdb_reg;
    logic                rda_ok_reg, rdb_ok_reg;
    logic [4:0]          rda_idx, rdb_idx;
    logic                rf_we;
    logic [4:0]          rf_widx;
    logic [63:0]         rf_wdata;

    logic [63:0] pc_reg;

    // decode of the latched instruction
    logic [31:0] w;
    logic        is_exec, lit, scaled, regoff, wb, post;
    logic [63:0] base_val, idx_val, op_a, op_b, sum, addr_calc;

    // per-item state
    logic [63:0]      addr_reg, bval_reg, xfer_reg;
    logic             exec_reg, load_reg, wide_reg, bwr_reg;
    logic [4:0]       rn_reg, rt_reg;
    logic [63:0]      rt_val, st_data, ld_data;
    logic [ROW_W-1:0] clr_row_reg;
    logic [2:0]       offs;
    logic [ROW_W-1:0] row;
    logic [7:0]       bank_q [NUM_BANKS];

    assign w       = item_reg.instr;
    assign is_exec = (item_reg.kind == KIND_EXEC);
    assign lit     = !w[31];
    assign scaled  = w[24];
    assign regoff  = w[21];
    assign wb      = !lit && !scaled && !regoff;
    assign post    = wb && !w[11];

    assign base_val = rda_ok_reg ? rda_reg : 64'd0;
    assign idx_val  = rdb_ok_reg ? rdb_reg : 64'd0;

    always_comb begin
        op_a = base_val;
        priority if (lit) begin
            op_a = pc_reg;
            op_b = {{43{w[23]}}, w[23:5], 2'b00};
        end else if (scaled) begin
            op_b = w[30] ? {49'd0, w[21:10], 3'b000} : {50'd0, w[21:10], 2'b00};
        end else if (regoff) begin
            op_b = idx_val;
        end else begin
            op_b = {{55{w[20]}}, w[20:12]};
        end
    end

    assign sum       = op_a + op_b;
    assign addr_calc = post ? op_a : sum;

    // register file ports
    assign rda_idx = s_data.instr[9:5];
    assign rdb_idx = cmd.accept ? s_data.instr[20:16] : w[4:0];

    always_comb begin
        rf_we    = 1'b0;
        rf_widx  = item_reg.reg_number;
        rf_wdata = item_reg.value;
        if (cmd.load_wb) begin
            rf_we    = 1'b1;
            rf_widx  = rt_reg;
            rf_wdata = ld_data;
        end else if (cmd.calc && is_exec && wb) begin
            rf_we    = 1'b1;
            rf_widx  = w[9:5];
            rf_wdata = sum;
        end else if (cmd.calc && (item_reg.kind == KIND_SET_REG)) begin
            rf_we    = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (rf_we && (rf_widx != ZERO_REG)) begin
            rf_mem[rf_widx] <= rf_wdata;
        end
        if (cmd.accept) begin
            rda_reg    <= rf_mem[rda_idx];
            rda_ok_reg <= (rda_idx != ZERO_REG) && rf_valid_reg[rda_idx];
        end
        if (cmd.accept || cmd.calc) begin
            rdb_reg    <= rf_mem[rdb_idx];
            rdb_ok_reg <= (rdb_idx != ZERO_REG) && rf_valid_reg[rdb_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rf_valid_reg <= '0;
            pc_reg       <= 64'd0;
            clr_row_reg  <= '0;
        end else begin
            if (rf_we && (rf_widx != ZERO_REG)) begin
                rf_valid_reg[rf_widx] <= 1'b1;
            end
            if (cmd.calc) begin
                if (is_exec) begin
                    pc_reg <= pc_reg + 64'd4;
                end else if (item_reg.kind == KIND_SET_PC) begin
                    pc_reg <= item_reg.value;
                end
            end
            if (cmd.clear) begin
                clr_row_reg <= clr_row_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            item_reg <= s_data;
        end
        if (cmd.calc) begin
            exec_reg <= is_exec;
            if (is_exec) begin
                addr_reg <= addr_calc;
                load_reg <= lit || w[22];
                wide_reg <= w[30];
                bwr_reg  <= wb;
                bval_reg <= wb ? sum : 64'd0;
                rn_reg   <= lit ? 5'd0 : w[9:5];
                rt_reg   <= w[4:0];
            end else begin
                // doubleword setup write goes down the store path
                addr_reg <= {48'd0, item_reg.mem_address};
                load_reg <= 1'b0;
                wide_reg <= 1'b1;
                bwr_reg  <= 1'b0;
                bval_reg <= 64'd0;
                rn_reg   <= 5'd0;
                rt_reg   <= 5'd0;
            end
        end
        if (cmd.mem && !load_reg) begin
            xfer_reg <= st_data;
        end else if (cmd.load_wb) begin
            xfer_reg <= ld_data;
        end
        if (cmd.res_load) begin
            res_reg.access_address <= exec_reg ? addr_reg : 64'd0;
            res_reg.is_load        <= exec_reg && load_reg;
            res_reg.is_wide        <= exec_reg && wide_reg;
            res_reg.transfer_value <= exec_reg ? xfer_reg : 64'd0;
            res_reg.target_number  <= rt_reg;
            res_reg.base_written   <= bwr_reg;
            res_reg.base_number    <= rn_reg;
            res_reg.base_value     <= bval_reg;
            res_reg.pc_after       <= pc_reg;
        end
    end

    // base was written in the same cycle Rt was read
    assign rt_val = (bwr_reg && (rn_reg == rt_reg) && (rt_reg != ZERO_REG)) ? bval_reg :
                    (rdb_ok_reg ? rdb_reg : 64'd0);
    assign st_data = !exec_reg ? item_reg.value :
                     (wide_reg ? rt_val : {32'd0, rt_val[31:0]});

    // byte-interleaved memory: bank b holds the bytes whose address is b modulo 8
    assign offs = addr_reg[2:0];
    assign row  = addr_reg[ROW_W+2:3];

    for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
        logic [7:0]        bmem [ROWS];
        logic [7:0]        brd_reg;
        logic [BANK_W-1:0] lane;
        logic [ROW_W-1:0]  brow, waddr;
        logic              wrap, bwe;
        logic [7:0]        bwd;

        assign lane  = BANK_W'(b) - offs;
        assign wrap  = (BANK_W'(b) < offs);
        assign brow  = row + {{(ROW_W-1){1'b0}}, wrap};
        assign bwe   = cmd.clear || (cmd.mem && !load_reg && (wide_reg || !lane[2]));
        assign bwd   = cmd.clear ? 8'd0 : st_data[{lane, 3'b000} +: 8];
        assign waddr = cmd.clear ? clr_row_reg : brow;

        always_ff @(posedge aclk) begin
            if (bwe) begin
                bmem[waddr] <= bwd;
            end
            if (cmd.mem && load_reg) begin
                brd_reg <= bmem[brow];
            end
        end

        assign bank_q[b] = brd_reg;
    end

    always_comb begin
        logic [BANK_W-1:0] sel;
        ld_data = 64'd0;
        for (int k = 0; k < NUM_BANKS; k++) begin
            sel = BANK_W'(k) + offs;
            if (wide_reg || (k < NUM_BANKS / 2)) begin
                ld_data[k*8 +: 8] = bank_q[sel];
            end
        end
    end

    assign sts.clear_last = &clr_row_reg;
    assign sts.setup_only = (item_reg.kind == KIND_SET_REG) || (item_reg.kind == KIND_SET_PC);
    assign sts.needs_load = load_reg;

    assign m_data = res_reg;

endmodule

// File: tb/a64_load_store_unit_checker.sv
module a64_load_store_unit_checker #(
    parameter int MEM_BYTES = 65536
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  a64lsu_pkg::in_item_t  s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  a64lsu_pkg::out_item_t m_data,
    output int                    mismatch_count,
    output int                    results_pending,
    output int                    results_checked
);
    import a64lsu_pkg::*;

    logic [63:0] xregs [NUM_REGS];
    logic [63:0] pc_shadow;
    logic [7:0]  mem_image [MEM_BYTES];

    out_item_t   access_q [$];
    out_item_t   oldest;
    int          fail_cnt;
    int          match_cnt;

    assign mismatch_count  = fail_cnt;
    assign results_checked = match_cnt;

    function automatic logic [63:0] xreg_read(logic [4:0] n);
        return (n == ZERO_REG) ? 64'd0 : xregs[n];
    endfunction

    function automatic void xreg_write(logic [4:0] n, logic [63:0] v);
        if (n != ZERO_REG)
            xregs[n] = v;
    endfunction

    // little endian, every byte lane wraps on its own
    function automatic logic [63:0] mem_load(logic [63:0] addr, int nbytes);
        logic [63:0] v;
        logic [63:0] idx;
        v = '0;
        for (int k = 0; k < nbytes; k++) begin
            idx = (addr + 64'(k)) & 64'(MEM_BYTES - 1);
            v[8*k +: 8] = mem_image[idx];
        end
        return v;
    endfunction

    function automatic void mem_store(logic [63:0] addr, logic [63:0] v, int nbytes);
        logic [63:0] idx;
        for (int k = 0; k < nbytes; k++) begin
            idx = (addr + 64'(k)) & 64'(MEM_BYTES - 1);
            mem_image[idx] = v[8*k +: 8];
        end
    endfunction

    function automatic out_item_t predict_access(in_item_t it);
        out_item_t   r;
        logic [31:0] w;
        logic [63:0] addr;
        logic [63:0] old_base;
        logic [63:0] off;
        int          nbytes;
        r = '0;
        w = it.instr;
        case (it.kind)
            KIND_SET_REG:   xreg_write(it.reg_number, it.value);
            KIND_WRITE_MEM: mem_store(64'(it.mem_address), it.value, 8);
            KIND_SET_PC:    pc_shadow = it.value;
            default: begin
                r.target_number = w[4:0];
                r.is_wide       = w[30];
                r.is_load       = w[22];
                nbytes          = w[30] ? 8 : 4;
                if (!w[31]) begin
                    // literal: pc + simm19 * 4, always a load
                    addr      = pc_shadow + ({{45{w[23]}}, w[23:5]} << 2);
                    r.is_load = 1'b1;
                end else begin
                    r.base_number = w[9:5];
                    if (w[24]) begin
                        addr = xreg_read(w[9:5]) + (64'(w[21:10]) << (w[30] ? 3 : 2));
                    end else if (w[21]) begin
                        addr = xreg_read(w[9:5]) + xreg_read(w[20:16]);
                    end else begin
                        off      = {{55{w[20]}}, w[20:12]};
                        old_base = xreg_read(w[9:5]);
                        addr     = w[11] ? old_base + off : old_base;
                        r.base_value   = old_base + off;
                        r.base_written = 1'b1;
                        // writeback lands before the transfer
                        xreg_write(w[9:5], old_base + off);
                    end
                end
                r.access_address = addr;
                if (r.is_load) begin
                    r.transfer_value = mem_load(addr, nbytes);
                    xreg_write(w[4:0], r.transfer_value);
                end else begin
                    r.transfer_value = xreg_read(w[4:0]);
                    if (!w[30])
                        r.transfer_value[63:32] = '0;
                    mem_store(addr, r.transfer_value, nbytes);
                end
                pc_shadow = pc_shadow + 64'd4;
            end
        endcase
        r.pc_after = pc_shadow;
        return r;
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_cnt++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++)
                xregs[i] = '0;
            for (int i = 0; i < MEM_BYTES; i++)
                mem_image[i] = '0;
            pc_shadow = '0;
            access_q.delete();
        end else begin
            if (s_valid && s_ready)
                access_q.push_back(predict_access(s_data));
            if (m_valid && m_ready) begin
                if (access_q.size() == 0) begin
                    $error("result transfer with no prediction waiting");
                    fail_cnt++;
                end else begin
                    oldest = access_q.pop_front();
                    check_field("access_address", oldest.access_address,
                                m_data.access_address);
                    check_field("is_load", 64'(oldest.is_load), 64'(m_data.is_load));
                    check_field("is_wide", 64'(oldest.is_wide), 64'(m_data.is_wide));
                    check_field("transfer_value", oldest.transfer_value,
                                m_data.transfer_value);
                    check_field("target_number", 64'(oldest.target_number),
                                64'(m_data.target_number));
                    check_field("base_written", 64'(oldest.base_written),
                                64'(m_data.base_written));
                    check_field("base_number", 64'(oldest.base_number),
                                64'(m_data.base_number));
                    check_field("base_value", oldest.base_value, m_data.base_value);
                    check_field("pc_after", oldest.pc_after, m_data.pc_after);
                    match_cnt++;
                end
            end
        end
        results_pending <= access_q.size();
    end

endmodule

// File: tb/a64_load_store_unit_tb.sv
module a64_load_store_unit_tb;
    import a64lsu_pkg::*;

    localparam int MEM_BYTES   = 65536;
    localparam int RAND_ITEMS  = 650;
    localparam int CYCLE_LIMIT = 200000;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    int mismatch_count;
    int results_pending;
    int results_checked;
    int n_items;
    int n_exec;
    int cycle_count;
    bit calm;

    a64_load_store_unit #(.MEM_BYTES(MEM_BYTES)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    a64_load_store_unit_checker #(.MEM_BYTES(MEM_BYTES)) checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending),
        .results_checked (results_checked)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic logic [31:0] enc_literal(bit wide, logic [18:0] simm19, logic [4:0] rt);
        return {1'b0, wide, 6'd0, simm19, rt};
    endfunction

    function automatic logic [31:0] enc_uimm(bit wide, bit load, logic [11:0] imm12,
                                              logic [4:0] rn, logic [4:0] rt);
        logic [31:0] w;
        w = '0;
        w[31] = 1'b1; w[30] = wide; w[24] = 1'b1; w[22] = load;
        w[21:10] = imm12; w[9:5] = rn; w[4:0] = rt;
        return w;
    endfunction

    function automatic logic [31:0] enc_regoff(bit wide, bit load, logic [4:0] rm,
                                                logic [4:0] rn, logic [4:0] rt);
        logic [31:0] w;
        w = '0;
        w[31] = 1'b1; w[30] = wide; w[22] = load; w[21] = 1'b1;
        w[20:16] = rm; w[9:5] = rn; w[4:0] = rt;
        return w;
    endfunction

    function automatic logic [31:0] enc_indexed(bit wide, bit load, bit pre, logic [8:0] simm9,
                                                 logic [4:0] rn, logic [4:0] rt);
        logic [31:0] w;
        w = '0;
        w[31] = 1'b1; w[30] = wide; w[22] = load;
        w[20:12] = simm9; w[11] = pre; w[9:5] = rn; w[4:0] = rt;
        return w;
    endfunction

    // ignored fields get random content so every input bit toggles
    function automatic in_item_t make_item(logic [1:0] kind, logic [31:0] instr,
                                           logic [4:0] rnum, logic [15:0] maddr,
                                           logic [63:0] val);
        in_item_t it;
        it.kind        = kind;
        it.instr       = (kind == KIND_EXEC) ? instr : $urandom;
        it.reg_number  = (kind == KIND_SET_REG) ? rnum : 5'($urandom_range(0, 30));
        it.mem_address = (kind == KIND_WRITE_MEM) ? maddr : 16'($urandom);
        it.value       = (kind == KIND_EXEC) ? {$urandom, $urandom} : val;
        return it;
    endfunction

    // mostly inside the low window so loads see earlier stores
    function automatic logic [63:0] near_address();
        logic [63:0] a;
        a = 64'($urandom_range(0, 'hFFF));
        case ($urandom_range(0, 3))
            0: a[63:16] = 48'({$urandom, $urandom});
            1: a[15:0]  = 16'($urandom_range('hFFE0, 'hFFFF));
            default: ;
        endcase
        return a;
    endfunction

    function automatic logic [31:0] random_access();
        int          form;
        bit          wide;
        bit          load;
        logic [4:0]  rt;
        logic [4:0]  rn;
        logic [4:0]  rm;
        logic [18:0] simm19;
        logic [11:0] imm12;
        form = $urandom_range(0, 99);
        wide = 1'($urandom);
        load = 1'($urandom);
        rt   = 5'($urandom);
        rn   = 5'($urandom);
        rm   = 5'($urandom);
        if (form < 15) begin
            simm19 = ($urandom_range(0, 3) == 0) ? 19'($urandom)
                                                : 19'($urandom_range(0, 127) - 64);
            return enc_literal(wide, simm19, rt) | ($urandom & 32'h3F00_0000);
        end else if (form < 40) begin
            imm12 = ($urandom_range(0, 4) == 0) ? 12'($urandom) : 12'($urandom_range(0, 31));
            return enc_uimm(wide, load, imm12, rn, rt) | ($urandom & 32'h3E80_0000);
        end else if (form < 65) begin
            return enc_regoff(wide, load, rm, rn, rt) | ($urandom & 32'h3E80_FC00);
        end
        return enc_indexed(wide, load, 1'($urandom), 9'($urandom), rn, rt)
               | ($urandom & 32'h3E80_0400);
    endfunction

    function automatic in_item_t random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 14)
            return make_item(KIND_SET_REG, '0, 5'($urandom_range(0, 30)), '0,
                             $urandom_range(0, 1) ? near_address() : {$urandom, $urandom});
        if (pick < 24)
            return make_item(KIND_WRITE_MEM, '0, '0,
                             ($urandom_range(0, 4) != 0) ? 16'($urandom_range(0, 'hFFF))
                                                         : 16'($urandom),
                             {$urandom, $urandom});
        if (pick < 27)
            return make_item(KIND_SET_PC, '0, '0, '0, near_address());
        if (pick < 31)
            return make_item(KIND_EXEC, $urandom, '0, '0, '0);
        return make_item(KIND_EXEC, random_access(), '0, '0, '0);
    endfunction

    task automatic send_item(in_item_t it);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        n_items++;
        if (it.kind == KIND_EXEC)
            n_exec++;
    endtask

    task automatic source_gap(int n);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (n - 1) @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (results_pending != 0) @(negedge aclk);
    endtask

    // result side: random stall bursts plus one long hold-off
    initial begin
        int stall_left;
        int window;
        bit jittery;
        bit long_done;
        stall_left = 0;
        window     = 0;
        jittery    = 1'b0;
        long_done  = 1'b0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (window == 0) begin
                window  = 64;
                jittery = ($urandom_range(0, 2) != 0);
            end
            window--;
            if (!calm && stall_left == 0) begin
                if (!long_done && results_checked >= 250) begin
                    stall_left = 90;
                    long_done  = 1'b1;
                end else if (jittery && $urandom_range(0, 4) == 0) begin
                    stall_left = $urandom_range(1, 12);
                end
            end
            m_ready <= (stall_left == 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("a64_load_store_unit_tb failed");
        $finish;
    end

    initial begin
        in_item_t directed [$];
        bit       quiet;
        s_valid = 1'b0;
        s_data  = '0;
        aresetn = 1'b0;
        calm    = 1'b0;
        quiet   = 1'b0;
        n_items = 0;
        n_exec  = 0;

        directed.push_back(make_item(KIND_SET_REG, '0, 5'd0, '0, 64'hFFFF_FFFF_FFFF_FFFF));
        directed.push_back(make_item(KIND_SET_REG, '0, 5'd30, '0, 64'h0000_0000_0000_0100));
        directed.push_back(make_item(KIND_WRITE_MEM, '0, '0, 16'hFFFC, 64'h8877_6655_4433_2211));
        directed.push_back(make_item(KIND_WRITE_MEM, '0, '0, 16'h0100, 64'h0123_4567_89AB_CDEF));
        directed.push_back(make_item(KIND_SET_PC, '0, '0, '0, 64'h0000_0000_0000_0400));
        // literal offsets at both ends of the simm19 range
        directed.push_back(make_item(KIND_EXEC, enc_literal(1, 19'h3FFFF, 5'd1), '0, '0, '0));
        directed.push_back(make_item(KIND_EXEC, enc_literal(0, 19'h40000, 5'd2), '0, '0, '0));
        // zero register as base, largest imm12
        directed.push_back(make_item(KIND_EXEC, enc_uimm(1, 1, 12'hFFF, ZERO_REG, 5'd3),
                                     '0, '0, '0));
        directed.push_back(make_item(KIND_EXEC, enc_uimm(0, 0, 12'h000, 5'd30, 5'd0),
                                     '0, '0, '0));
        // load into the zero register is dropped
        directed.push_back(make_item(KIND_EXEC, enc_uimm(1, 1, 12'h000, 5'd30, ZERO_REG),
                                     '0, '0, '0));
        directed.push_back(make_item(KIND_EXEC, enc_regoff(1, 1, ZERO_REG, 5'd30, 5'd4),
                                     '0, '0, '0));
        directed.push_back(make_item(KIND_EXEC, enc_regoff(0, 1, 5'd30, 5'd0, 5'd5),
                                     '0, '0, '0));
        // base equal to target: store sees the new base, load overwrites it
        directed.push_back(make_item(KIND_EXEC, enc_indexed(1, 0, 1, 9'h100, 5'd30, 5'd30),
                                     '0, '0, '0));
        directed.push_back(make_item(KIND_EXEC, enc_indexed(0, 1, 0, 9'h0FF, 5'd30, 5'd30),
                                     '0, '0, '0));
        directed.push_back(make_item(KIND_EXEC, enc_indexed(1, 1, 1, 9'h1FF, ZERO_REG, 5'd6),
                                     '0, '0, '0));
        directed.push_back(make_item(KIND_EXEC, 32'hFFFF_FFFF, '0, '0, '0));
        directed.push_back(make_item(KIND_EXEC, 32'h0000_0000, '0, '0, '0));
        directed.push_back(make_item(KIND_SET_PC, '0, '0, '0, 64'hFFFF_FFFF_FFFF_FFFC));
        directed.push_back(make_item(KIND_EXEC, enc_literal(1, 19'h00000, 5'd7), '0, '0, '0));
        // doubleword read across the top of memory
        directed.push_back(make_item(KIND_SET_REG, '0, 5'd8, '0, 64'h0000_0000_0000_FFF9));
        directed.push_back(make_item(KIND_EXEC, enc_regoff(1, 1, ZERO_REG, 5'd8, 5'd9),
                                     '0, '0, '0));
        directed.push_back(make_item(KIND_EXEC, enc_uimm(0, 0, 12'h001, 5'd0, 5'd1),
                                     '0, '0, '0));
        directed.push_back(make_item(KIND_EXEC, enc_uimm(1, 1, 12'h000, 5'd8, 5'd10),
                                     '0, '0, '0));

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i]) begin
            send_item(directed[i]);
            if ($urandom_range(0, 3) == 0)
                source_gap($urandom_range(1, 12));
        end

        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (i % 40 == 0)
                quiet = ($urandom_range(0, 2) == 0);
            if (i == 450) begin
                source_gap(1);
                wait_drained();
            end
            calm = (i >= RAND_ITEMS - 90);
            send_item(random_item());
            // keep offering back to back around the long result hold-off
            if (!calm && !quiet && !(i >= 200 && i < 330) && $urandom_range(0, 2) == 0)
                source_gap($urandom_range(1, 12));
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        wait_drained();
        repeat (20) @(posedge aclk);

        $display("%0d items driven (%0d instructions, %0d setup), %0d results checked",
                 n_items, n_exec, n_items - n_exec, results_checked);
        $display("%0d field mismatches, %0d results outstanding", mismatch_count,
                 results_pending);
        if (mismatch_count == 0 && results_pending == 0)
            $display("a64_load_store_unit_tb passed");
        else
            $display("a64_load_store_unit_tb failed");
        $finish;
    end

endmodule
